FILE: hdl/crst_pkg.sv
`default_nettype none

package crst_pkg;

  // Register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_BYTE_LIMIT  = 2'd0;
  localparam logic [1:0] REG_CHUNK_LIMIT = 2'd1;
  localparam logic [1:0] REG_GROUP_SIZE  = 2'd2;

  // Register reset values
  localparam logic [23:0] BYTE_LIMIT_RST  = 24'd602112;
  localparam logic [10:0] CHUNK_LIMIT_RST = 11'd1024;
  localparam logic [15:0] GROUP_SIZE_RST  = 16'd588;

  // Depth of the queue between front and back (power of two)
  localparam int unsigned QDEPTH = 2;

  // Request codes as they arrive on tuser
  typedef enum logic [1:0] {
    REQ_CHUNK   = 2'd0,
    REQ_TAKE    = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_e;

  // Classes assigned by the front end
  typedef enum logic [2:0] {
    K_NONIP,    // chunk without IPv4 header
    K_STRAY,    // IPv4 chunk for a slot beyond the table
    K_CHUNK,    // IPv4 chunk for a slot in the table
    K_TAKE,     // take request for a slot in the table
    K_RELEASE,  // release request for a slot in the table
    K_IGNORE    // request that can only be refused
  } kind_e;

  // Result action codes as they leave on tuser
  typedef enum logic [1:0] {
    ACT_STORED = 2'd0,
    ACT_DUP    = 2'd1,
    ACT_NONIP  = 2'd2,
    ACT_REQ    = 2'd3
  } action_e;

  typedef struct packed {
    kind_e       kind;
    logic [4:0]  slot_id;
    logic [15:0] chunk_bytes;
    logic        last_of_burst;
  } item_t;

  typedef struct packed {
    logic [23:0] byte_limit;
    logic [10:0] chunk_limit;
    logic [15:0] group_size;
  } cfg_t;

  typedef struct packed {
    action_e     action;
    logic [9:0]  chunk_position;
    logic        slot_completed;
    logic [31:0] ready_bits;
    logic        group_done;
    logic        burst_end;
  } result_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic  empty;
    item_t item;
  } q_stat_t;

endpackage

`default_nettype wire

FILE: hdl/chunk_reassembly_slot_tracker.sv
// A request is queued, read from the slot table in the back end's read phase
// and registered into the result in its execute phase, which waits while a
// stalled result holds the output register. Each request's slot table read then
// write ends before the next is popped; a 2-entry queue decouples the input side.
// Reset: rst_ni is asynchronous, active low; it empties the queue, clears the
// slot valid bits, ready mask and arrival counter and loads register defaults.
`default_nettype none

module chunk_reassembly_slot_tracker import crst_pkg::*; #(
  parameter int unsigned SLOTS      = 32,
  parameter int unsigned MAX_CHUNKS = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Request stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // tdata: is_ipv4[0], slot_id[5:1], chunk_bytes[21:6], zero[23:22]
  input  wire logic [23:0] s_axis_tdata_i,
  // tuser: req_type[1:0]
  input  wire logic [1:0]  s_axis_tuser_i,
  // tlast: last_of_burst
  input  wire logic        s_axis_tlast_i,
  // Result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // tdata: chunk_position[9:0], slot_completed[10], ready_bits[42:11],
  //        group_done[43], zero[47:44]
  output logic [47:0]      m_axis_tdata_o,
  // tuser: action[1:0]
  output logic [1:0]       m_axis_tuser_o,
  // tlast: burst_end
  output logic             m_axis_tlast_o,
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t    cfg_q;
  logic    q_push, q_full, q_pop;
  item_t   q_item;
  q_stat_t q_stat;
  result_t res;
  logic    cfg_wr;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.byte_limit  <= BYTE_LIMIT_RST;
      cfg_q.chunk_limit <= CHUNK_LIMIT_RST;
      cfg_q.group_size  <= GROUP_SIZE_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_BYTE_LIMIT:  cfg_q.byte_limit  <= pwdata[23:0];
        REG_CHUNK_LIMIT: cfg_q.chunk_limit <= pwdata[10:0];
        REG_GROUP_SIZE:  cfg_q.group_size  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BYTE_LIMIT:  prdata = {8'd0, cfg_q.byte_limit};
      REG_CHUNK_LIMIT: prdata = {21'd0, cfg_q.chunk_limit};
      REG_GROUP_SIZE:  prdata = {16'd0, cfg_q.group_size};
      default:         prdata = '0;
    endcase
  end

  crst_front #(
    .SLOTS(SLOTS)
  ) u_front (
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_item_o       (q_item)
  );

  crst_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(q_push),
    .item_i(q_item),
    .full_o(q_full),
    .pop_i (q_pop),
    .stat_o(q_stat)
  );

  crst_back #(
    .SLOTS     (SLOTS),
    .MAX_CHUNKS(MAX_CHUNKS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_stat_i   (q_stat),
    .q_pop_o    (q_pop),
    .res_o      (res),
    .res_valid_o(m_axis_tvalid_o),
    .res_ready_i(m_axis_tready_i)
  );

  // Pack the result
  assign m_axis_tdata_o = {4'd0, res.group_done, res.ready_bits, res.slot_completed,
                           res.chunk_position};
  assign m_axis_tuser_o = res.action;
  assign m_axis_tlast_o = res.burst_end;

endmodule

`default_nettype wire

FILE: hdl/crst_front.sv
`default_nettype none

module crst_front import crst_pkg::*; #(
  parameter int unsigned SLOTS = 32
) (
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // tdata: is_ipv4[0], slot_id[5:1], chunk_bytes[21:6], zero[23:22]
  input  wire logic [23:0] s_axis_tdata_i,
  // tuser: req_type[1:0]
  input  wire logic [1:0]  s_axis_tuser_i,
  input  wire logic        s_axis_tlast_i,
  input  wire logic        q_full_i,
  output logic             q_push_o,
  output item_t            q_item_o
);

  req_e       req;
  logic       ipv4;
  logic [4:0] sid;
  logic       in_range;

  assign req      = req_e'(s_axis_tuser_i);
  assign ipv4     = s_axis_tdata_i[0];
  assign sid      = s_axis_tdata_i[5:1];
  assign in_range = (32'(sid) < SLOTS);

  // Accept whenever the queue has room
  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;

  // Classify the request before it is queued
  always_comb begin
    q_item_o.slot_id       = sid;
    q_item_o.chunk_bytes   = s_axis_tdata_i[21:6];
    q_item_o.last_of_burst = s_axis_tlast_i;
    case (req)
      REQ_CHUNK: begin
        if (!ipv4)         q_item_o.kind = K_NONIP;
        else if (in_range) q_item_o.kind = K_CHUNK;
        else               q_item_o.kind = K_STRAY;
      end
      REQ_TAKE:    q_item_o.kind = in_range ? K_TAKE : K_IGNORE;
      REQ_RELEASE: q_item_o.kind = in_range ? K_RELEASE : K_IGNORE;
      default:     q_item_o.kind = K_IGNORE;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/crst_fifo.sv
`default_nettype none

module crst_fifo import crst_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output q_stat_t    stat_o
);

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNTW = $clog2(QDEPTH + 1);

  item_t           buf_q [QDEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0] cnt_q;

  assign full_o      = (cnt_q == CNTW'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.item  = buf_q[rd_ptr_q];

  // Store pushed requests
  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wr_ptr_q] <= item_i;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/crst_back.sv
`default_nettype none

module crst_back import crst_pkg::*; #(
  parameter int unsigned SLOTS      = 32,
  parameter int unsigned MAX_CHUNKS = 1024
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire cfg_t    cfg_i,
  input  wire q_stat_t q_stat_i,
  output logic         q_pop_o,
  output result_t      res_o,
  output logic         res_valid_o,
  input  wire logic    res_ready_i
);

  localparam int unsigned NSLOT = (SLOTS < 32) ? SLOTS : 32;
  localparam int unsigned IW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int unsigned CW    = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned KW    = (CW > 11) ? CW : 11;
  localparam logic [KW-1:0] MAX_K = KW'(MAX_CHUNKS);

  typedef enum logic [1:0] {ST_FREE, ST_FILL, ST_DONE, ST_TAKEN} slot_st_e;
  typedef enum logic {S_RD, S_EX} phase_e;

  // Slot table
  slot_st_e    st_mem [NSLOT];
  logic [23:0] bt_mem [NSLOT];
  logic [CW-1:0] cc_mem [NSLOT];

  phase_e        phase_q;
  item_t         item_q;
  slot_st_e      st_rd_q;
  logic [23:0]   bt_rd_q;
  logic [CW-1:0] cc_rd_q;
  logic          hit_q;
  logic [NSLOT-1:0] vld_q;
  logic [31:0]   ready_q, ready_d;
  logic [15:0]   arr_q, arr_d;
  result_t       res_q, res_d;
  logic          res_vld_q;

  logic          fin;
  logic [IW-1:0] rd_idx, wr_idx;
  logic          we;
  slot_st_e      st_cur, st_fill, st_new;
  logic [23:0]   bt_cur, bt_new;
  logic [CW-1:0] cc_cur, cc_fill, cc_new;
  logic [24:0]   sum;
  logic [15:0]   arr_inc, pos_wide;
  logic [KW-1:0] cc_ext;
  logic          restart, complete;

  // Pop in the read phase, finish once the output register is free
  assign q_pop_o = (phase_q == S_RD) && !q_stat_i.empty;
  assign fin     = (phase_q == S_EX) && (!res_vld_q || res_ready_i);

  always_comb begin
    if (q_stat_i.item.kind == K_CHUNK || q_stat_i.item.kind == K_TAKE ||
        q_stat_i.item.kind == K_RELEASE) begin
      rd_idx = q_stat_i.item.slot_id[IW-1:0];
    end else begin
      rd_idx = '0;
    end
  end
  assign wr_idx = item_q.slot_id[IW-1:0];

  // Entries never written read as free and empty
  assign st_cur = hit_q ? st_rd_q : ST_FREE;
  assign bt_cur = hit_q ? bt_rd_q : '0;
  assign cc_cur = hit_q ? cc_rd_q : '0;

  // Chunk arithmetic
  assign restart  = (st_cur == ST_FREE) || (bt_cur == '0);
  assign st_fill  = restart ? ST_FILL : st_cur;
  assign cc_fill  = restart ? '0 : cc_cur;
  assign cc_new   = cc_fill + 1'b1;
  assign cc_ext   = KW'(cc_new);
  assign sum      = {1'b0, bt_cur} + {9'd0, item_q.chunk_bytes};
  assign bt_new   = sum[24] ? 24'hFF_FFFF : sum[23:0];
  assign complete = (bt_new >= cfg_i.byte_limit) || (cc_ext >= KW'(cfg_i.chunk_limit)) ||
                    (cc_ext >= MAX_K);
  assign pos_wide = 16'(cc_fill);
  assign arr_inc  = arr_q + 16'd1;

  // Work out the slot update and the result
  always_comb begin
    we                   = 1'b0;
    st_new               = st_cur;
    res_d.action         = ACT_REQ;
    res_d.chunk_position = '0;
    res_d.slot_completed = 1'b0;
    res_d.group_done     = 1'b0;
    res_d.burst_end      = item_q.last_of_burst;
    ready_d              = ready_q;
    arr_d                = arr_q;
    case (item_q.kind)
      K_NONIP: res_d.action = ACT_NONIP;
      K_STRAY, K_CHUNK: begin
        if (arr_inc >= cfg_i.group_size) begin
          arr_d            = arr_inc - cfg_i.group_size;
          res_d.group_done = 1'b1;
        end else begin
          arr_d = arr_inc;
        end
        res_d.action = ACT_DUP;
        if (item_q.kind == K_CHUNK && st_fill == ST_FILL) begin
          we                   = 1'b1;
          res_d.action         = ACT_STORED;
          res_d.chunk_position = pos_wide[9:0];
          st_new               = ST_FILL;
          ready_d[item_q.slot_id] = 1'b0;
          if (complete) begin
            st_new                  = ST_DONE;
            ready_d[item_q.slot_id] = 1'b1;
            res_d.slot_completed    = 1'b1;
          end
        end
      end
      K_TAKE: begin
        if (st_cur == ST_DONE) begin
          we                      = 1'b1;
          st_new                  = ST_TAKEN;
          ready_d[item_q.slot_id] = 1'b0;
          res_d.slot_completed    = 1'b1;
        end
      end
      K_RELEASE: begin
        if (st_cur == ST_TAKEN) begin
          we                      = 1'b1;
          st_new                  = ST_FREE;
          ready_d[item_q.slot_id] = 1'b0;
          res_d.slot_completed    = 1'b1;
        end
      end
      default: ;
    endcase
    res_d.ready_bits = ready_d;
  end

  // Slot table read in the read phase, write in the execute phase; a take keeps
  // the byte total and chunk count
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      st_rd_q <= st_mem[rd_idx];
      bt_rd_q <= bt_mem[rd_idx];
      cc_rd_q <= cc_mem[rd_idx];
    end
    if (fin && we) begin
      st_mem[wr_idx] <= st_new;
      bt_mem[wr_idx] <= (item_q.kind == K_CHUNK)   ? bt_new :
                        (item_q.kind == K_RELEASE) ? 24'd0  : bt_cur;
      cc_mem[wr_idx] <= (item_q.kind == K_CHUNK)   ? cc_new :
                        (item_q.kind == K_RELEASE) ? '0     : cc_cur;
    end
  end

  // Sequencer, slot valid bits, ready mask, arrival counter, output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= S_RD;
      item_q    <= '0;
      hit_q     <= 1'b0;
      vld_q     <= '0;
      ready_q   <= '0;
      arr_q     <= '0;
      res_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      if (fin) begin
        res_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        res_vld_q <= 1'b0;
      end
      case (phase_q)
        S_RD: begin
          if (q_pop_o) begin
            item_q  <= q_stat_i.item;
            hit_q   <= vld_q[rd_idx];
            phase_q <= S_EX;
          end
        end
        S_EX: begin
          if (fin) begin
            if (we) vld_q[wr_idx] <= 1'b1;
            ready_q   <= ready_d;
            arr_q     <= arr_d;
            res_q     <= res_d;
            phase_q   <= S_RD;
          end
        end
        default: phase_q <= S_RD;
      endcase
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_vld_q;

endmodule

`default_nettype wire

FILE: hdl/crst_checker.sv
`default_nettype none

module crst_checker import crst_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [47:0] m_axis_tdata_o,
  input wire logic [1:0]  m_axis_tuser_o
);

  // Hold a stalled result
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // No result while held in reset
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni && $past(!rst_ni) |-> !m_axis_tvalid_o)
    else $error("result valid during reset");

  // Non-IPv4 drop carries no position, completion or group flag
  a_nonip_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == ACT_NONIP |->
      m_axis_tdata_o[10:0] == 11'd0 && !m_axis_tdata_o[43])
    else $error("non-IPv4 drop with side fields set");

  // Duplicate drop carries no position and no completion
  a_dup_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == ACT_DUP |-> m_axis_tdata_o[10:0] == 11'd0)
    else $error("duplicate drop with position or completion");

  // Request answers never close an arrival group
  a_req_nogroup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == ACT_REQ |->
      !m_axis_tdata_o[43] && m_axis_tdata_o[9:0] == 10'd0)
    else $error("request answer with group flag or position");

endmodule

bind chunk_reassembly_slot_tracker crst_checker u_crst_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);

`default_nettype wire

FILE: verif/chunk_reassembly_slot_tracker_test.sv
module chunk_reassembly_slot_tracker_test;
  import crst_pkg::*;

  localparam int unsigned SLOT_COUNT    = 32;
  localparam int unsigned CHUNK_CAP     = 1024;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned LONG_HOLD     = 100;

  typedef enum logic [1:0] {
    SLOT_FREE     = 2'd0,
    SLOT_FILLING  = 2'd1,
    SLOT_COMPLETE = 2'd2,
    SLOT_TAKEN    = 2'd3
  } slot_state_e;

  // One request as it travels on the input stream
  typedef struct packed {
    req_e        req;
    logic        is_ipv4;
    logic [4:0]  slot_id;
    logic [15:0] chunk_bytes;
    logic        last_of_burst;
  } slot_req_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the slot table and registers
  slot_state_e slot_state [SLOT_COUNT];
  logic [23:0] slot_bytes [SLOT_COUNT];
  logic [10:0] slot_chunks [SLOT_COUNT];
  logic [31:0] ready_shadow;
  logic [15:0] arrivals;
  logic [23:0] limit_bytes;
  logic [10:0] limit_chunks;
  logic [15:0] group_size;

  result_t     pending_results [$];

  int unsigned tx_gap_max;
  int unsigned rx_gap_max;
  int unsigned rx_hold;
  int unsigned stall_cycles;
  int unsigned mismatches;
  int unsigned requests_sent;
  int unsigned settings_used;
  int unsigned n_stored;
  int unsigned n_dropped;
  int unsigned n_completed;
  int unsigned n_granted;
  int unsigned n_refused;
  int unsigned n_groups;

  always #5 clk = ~clk;

  chunk_reassembly_slot_tracker #(
    .SLOTS      (SLOT_COUNT),
    .MAX_CHUNKS (CHUNK_CAP)
  ) u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Advance the shadow table by one request and return the result it causes
  function automatic result_t track_slot_update(input slot_req_t r);
    result_t     res;
    logic [24:0] total;
    logic [4:0]  s;
    s = r.slot_id;
    res = '0;
    res.action = ACT_REQ;
    res.burst_end = r.last_of_burst;
    case (r.req)
      REQ_CHUNK: begin
        if (!r.is_ipv4) begin
          res.action = ACT_NONIP;
        end else begin
          arrivals = arrivals + 16'd1;
          // restart a free slot, or any slot still holding no bytes
          if (slot_state[s] == SLOT_FREE || slot_bytes[s] == 24'd0) begin
            slot_chunks[s] = 11'd0;
            slot_state[s] = SLOT_FILLING;
            ready_shadow[s] = 1'b0;
          end
          if (slot_state[s] == SLOT_FILLING) begin
            res.action = ACT_STORED;
            res.chunk_position = slot_chunks[s][9:0];
            slot_chunks[s] = slot_chunks[s] + 11'd1;
            total = {1'b0, slot_bytes[s]} + {9'd0, r.chunk_bytes};
            slot_bytes[s] = total[24] ? 24'hFF_FFFF : total[23:0];
            if (slot_bytes[s] >= limit_bytes || slot_chunks[s] >= limit_chunks ||
                slot_chunks[s] >= 11'(CHUNK_CAP)) begin
              slot_state[s] = SLOT_COMPLETE;
              ready_shadow[s] = 1'b1;
              res.slot_completed = 1'b1;
            end
          end else begin
            res.action = ACT_DUP;
          end
          if (arrivals >= group_size) begin
            arrivals = arrivals - group_size;
            res.group_done = 1'b1;
          end
        end
      end
      REQ_TAKE: begin
        if (slot_state[s] == SLOT_COMPLETE) begin
          slot_state[s] = SLOT_TAKEN;
          ready_shadow[s] = 1'b0;
          res.slot_completed = 1'b1;
        end
      end
      REQ_RELEASE: begin
        if (slot_state[s] == SLOT_TAKEN) begin
          slot_state[s] = SLOT_FREE;
          slot_bytes[s] = 24'd0;
          slot_chunks[s] = 11'd0;
          ready_shadow[s] = 1'b0;
          res.slot_completed = 1'b1;
        end
      end
      default: ;
    endcase
    res.ready_bits = ready_shadow;
    return res;
  endfunction

  function automatic slot_req_t make_request(input req_e req, input logic is_ipv4,
                                             input logic [4:0] slot_id,
                                             input logic [15:0] chunk_bytes);
    slot_req_t r;
    r.req = req;
    r.is_ipv4 = is_ipv4;
    r.slot_id = slot_id;
    r.chunk_bytes = chunk_bytes;
    r.last_of_burst = 1'($urandom);
    return r;
  endfunction

  // Find a slot in the given state, starting the scan at a random slot
  function automatic logic [4:0] find_slot(input slot_state_e want,
                                           input logic [4:0] fallback);
    logic [4:0] s;
    s = 5'($urandom);
    for (int k = 0; k < SLOT_COUNT; k++) begin
      if (slot_state[s] == want) return s;
      s = s + 5'd1;
    end
    return fallback;
  endfunction

  // Mostly lifecycle traffic on a few hot slots, plus some noise
  function automatic slot_req_t random_request();
    slot_req_t   r;
    int unsigned pick;
    r.is_ipv4 = ($urandom_range(9, 0) != 0);
    r.slot_id = ($urandom_range(3, 0) == 0) ? 5'($urandom) : 5'($urandom_range(3, 0));
    case ($urandom_range(3, 0))
      0:       r.chunk_bytes = 16'd0;
      1:       r.chunk_bytes = 16'hFFFF;
      2:       r.chunk_bytes = 16'($urandom_range(255, 0));
      default: r.chunk_bytes = 16'($urandom);
    endcase
    r.last_of_burst = 1'($urandom);
    pick = $urandom_range(19, 0);
    if (pick < 12) begin
      r.req = REQ_CHUNK;
    end else if (pick < 15) begin
      r.req = REQ_TAKE;
      r.slot_id = find_slot(SLOT_COMPLETE, r.slot_id);
    end else if (pick < 18) begin
      r.req = REQ_RELEASE;
      r.slot_id = find_slot(SLOT_TAKEN, r.slot_id);
    end else if (pick < 19) begin
      r.req = ($urandom_range(1, 0) != 0) ? REQ_TAKE : REQ_RELEASE;
    end else begin
      r.req = REQ_UNUSED;
    end
    return r;
  endfunction

  function automatic int unsigned draw_gap_limit();
    case ($urandom_range(2, 0))
      0:       return 0;
      1:       return 3;
      default: return 14;
    endcase
  endfunction

  // Offer one request and hold it until accepted; tvalid stays high afterwards
  task automatic send_request(input slot_req_t r);
    int unsigned gap;
    gap = $urandom_range(tx_gap_max, 0);
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, r.chunk_bytes, r.slot_id, r.is_ipv4};
    s_tuser  <= r.req;
    s_tlast  <= r.last_of_burst;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(track_slot_update(r));
    requests_sent++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (index)
      REG_BYTE_LIMIT:  limit_bytes  = value[23:0];
      REG_CHUNK_LIMIT: limit_chunks = value[10:0];
      REG_GROUP_SIZE:  group_size   = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_limits(input logic [23:0] bytes, input logic [10:0] chunks,
                              input logic [15:0] group);
    drain_results();
    write_register(REG_BYTE_LIMIT, {8'd0, bytes});
    write_register(REG_CHUNK_LIMIT, {21'd0, chunks});
    write_register(REG_GROUP_SIZE, {16'd0, group});
    settings_used++;
  endtask

  task automatic report_mismatch(input string why, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s) at %0t: expected / actual", why, $realtime);
      $display("  action %0d / %0d, position %0d / %0d, completed %0b / %0b",
               want.action, got.action, want.chunk_position, got.chunk_position,
               want.slot_completed, got.slot_completed);
      $display("  ready %h / %h, group %0b / %0b, burst %0b / %0b",
               want.ready_bits, got.ready_bits, want.group_done, got.group_done,
               want.burst_end, got.burst_end);
    end
  endtask

  // Defaults: drops, refusals, restarts, completion by bytes, take and release
  task automatic test_request_kinds();
    tx_gap_max = 5;
    rx_gap_max = 5;
    send_request(make_request(REQ_CHUNK, 1'b0, 5'd3, 16'hFFFF));
    send_request(make_request(REQ_TAKE, 1'b1, 5'd3, 16'hFFFF));
    send_request(make_request(REQ_RELEASE, 1'b0, 5'd3, 16'd0));
    send_request(make_request(REQ_UNUSED, 1'b1, 5'd3, 16'h1234));
    send_request(make_request(REQ_CHUNK, 1'b1, 5'd0, 16'd0));
    send_request(make_request(REQ_CHUNK, 1'b1, 5'd0, 16'd100));
    send_request(make_request(REQ_CHUNK, 1'b1, 5'd0, 16'd5));
    send_request(make_request(REQ_TAKE, 1'b1, 5'd0, 16'd0));
    repeat (10) send_request(make_request(REQ_CHUNK, 1'b1, 5'd31, 16'hFFFF));
    send_request(make_request(REQ_CHUNK, 1'b1, 5'd31, 16'd1));
    send_request(make_request(REQ_RELEASE, 1'b1, 5'd31, 16'd0));
    send_request(make_request(REQ_TAKE, 1'b0, 5'd31, 16'hFFFF));
    send_request(make_request(REQ_TAKE, 1'b1, 5'd31, 16'd0));
    send_request(make_request(REQ_CHUNK, 1'b1, 5'd31, 16'd2));
    send_request(make_request(REQ_RELEASE, 1'b1, 5'd31, 16'd0));
    send_request(make_request(REQ_CHUNK, 1'b1, 5'd31, 16'd7));
  endtask

  // Zero chunk limit and zero group size; slots completed with no bytes restart
  task automatic test_zero_limits();
    apply_limits(24'hFF_FFFF, 11'd0, 16'd0);
    send_request(make_request(REQ_CHUNK, 1'b1, 5'd2, 16'd0));
    send_request(make_request(REQ_CHUNK, 1'b1, 5'd2, 16'd9));
    send_request(make_request(REQ_TAKE, 1'b1, 5'd2, 16'd0));
    send_request(make_request(REQ_CHUNK, 1'b1, 5'd2, 16'd3));
    send_request(make_request(REQ_RELEASE, 1'b1, 5'd2, 16'd0));
    send_request(make_request(REQ_CHUNK, 1'b1, 5'd4, 16'd0));
    send_request(make_request(REQ_TAKE, 1'b1, 5'd4, 16'd0));
    send_request(make_request(REQ_CHUNK, 1'b1, 5'd4, 16'd0));
    send_request(make_request(REQ_CHUNK, 1'b0, 5'd4, 16'd0));
    send_request(make_request(REQ_RELEASE, 1'b1, 5'd4, 16'd0));
    send_request(make_request(REQ_TAKE, 1'b1, 5'd4, 16'd0));
    send_request(make_request(REQ_RELEASE, 1'b1, 5'd4, 16'd0));
  endtask

  // Top limits: the byte total saturates instead of wrapping, so the slot completes
  task automatic test_byte_saturation();
    apply_limits(24'hFF_FFFF, 11'h7FF, 16'hFFFF);
    tx_gap_max = 0;
    rx_gap_max = 0;
    repeat (257) send_request(make_request(REQ_CHUNK, 1'b1, 5'd9, 16'hFFFF));
  endtask

  // Lowest limits: every slot ends complete and is then taken, so each ready bit is set and then falls
  task automatic test_ready_mask_sweep();
    apply_limits(24'd1, 11'd1, 16'd1);
    tx_gap_max = 2;
    rx_gap_max = 2;
    for (int s = 0; s < SLOT_COUNT; s++)
      send_request(make_request(REQ_CHUNK, 1'b1, 5'(s), 16'($urandom_range(65535, 1))));
    for (int s = 0; s < SLOT_COUNT; s++)
      send_request(make_request(REQ_TAKE, 1'($urandom), 5'(s), 16'($urandom)));
  endtask

  // Hold the result side for a long stretch so the input stalls, then pause
  task automatic test_backpressure();
    apply_limits(24'd1000, 11'd3, 16'd5);
    tx_gap_max = 0;
    rx_gap_max = 0;
    rx_hold = LONG_HOLD;
    repeat (16) send_request(random_request());
    drain_results();
    repeat (16) send_request(random_request());
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: apply_limits(24'd1, 11'd1, 16'd1);
        1: apply_limits(24'hFF_FFFF, 11'h7FF, 16'hFFFF);
        2: apply_limits(24'($urandom_range(300000, 1)), 11'($urandom_range(8, 1)),
                        16'($urandom_range(20, 1)));
        3: apply_limits(24'($urandom_range(262140, 1000)), 11'($urandom_range(16, 1)),
                        16'd0);
        default: apply_limits(24'($urandom_range(24'hFF_FFFF, 1)),
                              11'($urandom_range(6, 1)), 16'($urandom_range(65535, 1)));
      endcase
      for (int i = 0; i < 8; i++) begin
        if (i % 4 == 0) begin
          tx_gap_max = draw_gap_limit();
          rx_gap_max = draw_gap_limit();
        end
        send_request(random_request());
      end
    end
  endtask

  // Result side: random gaps, with a long hold-off when one is requested
  initial begin : result_sink
    int unsigned gap;
    m_tready = 1'b0;
    forever begin
      gap = $urandom_range(rx_gap_max, 0);
      if (gap != 0) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      do begin
        @(negedge clk);
        if (rx_hold != 0) begin
          m_tready <= 1'b0;
          repeat (rx_hold) @(negedge clk);
          rx_hold = 0;
        end
        m_tready <= 1'b1;
        @(posedge clk);
      end while (!m_tvalid);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && m_tvalid && m_tready) begin
      got.action         = action_e'(m_tuser);
      got.chunk_position = m_tdata[9:0];
      got.slot_completed = m_tdata[10];
      got.ready_bits     = m_tdata[42:11];
      got.group_done     = m_tdata[43];
      got.burst_end      = m_tlast;
      if (pending_results.size() == 0) begin
        report_mismatch("no result expected", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.action !== want.action || got.chunk_position !== want.chunk_position ||
            got.slot_completed !== want.slot_completed ||
            got.ready_bits !== want.ready_bits || got.group_done !== want.group_done ||
            got.burst_end !== want.burst_end)
          report_mismatch("field differs", want, got);
        case (want.action)
          ACT_STORED: n_stored++;
          ACT_REQ:    if (want.slot_completed) n_granted++; else n_refused++;
          default:    n_dropped++;
        endcase
        if (want.action == ACT_STORED && want.slot_completed) n_completed++;
        if (want.group_done) n_groups++;
      end
    end
  end

  // Watchdog: end the run when neither stream moves for too long
  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    rst_n    = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = REQ_CHUNK;
    s_tlast  = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    tx_gap_max = 0;
    rx_gap_max = 0;
    rx_hold    = 0;
    stall_cycles  = 0;
    mismatches    = 0;
    requests_sent = 0;
    settings_used = 1;
    n_stored = 0;
    n_dropped = 0;
    n_completed = 0;
    n_granted = 0;
    n_refused = 0;
    n_groups = 0;
    // initialise the shadow table to its reset state
    for (int s = 0; s < SLOT_COUNT; s++) begin
      slot_state[s]  = SLOT_FREE;
      slot_bytes[s]  = 24'd0;
      slot_chunks[s] = 11'd0;
    end
    ready_shadow = '0;
    arrivals     = '0;
    limit_bytes  = BYTE_LIMIT_RST;
    limit_chunks = CHUNK_LIMIT_RST;
    group_size   = GROUP_SIZE_RST;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    test_request_kinds();
    test_zero_limits();
    test_byte_saturation();
    test_ready_mask_sweep();
    test_backpressure();
    test_random_traffic();
    drain_results();

    $display("%0d requests under %0d register settings: %0d stored, %0d dropped, %0d completed",
             requests_sent, settings_used, n_stored, n_dropped, n_completed);
    $display("%0d takes/releases granted, %0d refused, %0d arrival groups, %0d mismatches",
             n_granted, n_refused, n_groups, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/crst_pkg.sv
hdl/crst_front.sv
hdl/crst_fifo.sv
hdl/crst_back.sv
hdl/chunk_reassembly_slot_tracker.sv
hdl/crst_checker.sv
verif/chunk_reassembly_slot_tracker_test.sv
